// ----- src/mrg_pkg.sv -----
// Shared constants, command codes and control/status types for the
// minimal-standard random generator. No dependencies.
`default_nettype none

package mrg_pkg;

    localparam int CMD_W   = 3;
    localparam int DATA_W  = 32;
    localparam int STATE_W = 31;
    localparam int MULT_W  = 16;
    localparam int PROD_W  = STATE_W + MULT_W;
    localparam int SPAN_W  = DATA_W + 1;

    localparam logic [MULT_W-1:0] LCG_MULT = 16'd48271;
    localparam logic [DATA_W-1:0] LCG_MOD  = 32'h7FFF_FFFF;
    localparam logic [STATE_W-1:0] STATE_RESET = 31'd1;

    // Remainder steps: one per bit of the state, which is the dividend.
    localparam int DIV_STEPS = STATE_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CMD_W-1:0] CMD_RAW   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_BYTE  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_BOOL  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_RANGE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SEED  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd5;

    typedef struct packed {
        logic load_in;
        logic mul;
        logic reduce;
        logic div_step;
        logic seed_load;
        logic out_load;
    } mrg_ctl_t;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             range_bad;
        logic             out_free;
    } mrg_sts_t;

endpackage

`default_nettype wire

// ----- src/mrg_if.sv -----
// Handshake channels of the random generator: the request and the response.
// Depends on mrg_pkg for field widths.
`default_nettype none

interface mrg_req_if;
    logic                             valid;
    logic                             ready;
    logic [mrg_pkg::CMD_W-1:0]        cmd;
    logic signed [mrg_pkg::DATA_W-1:0] seed_value;
    logic signed [mrg_pkg::DATA_W-1:0] range_low;
    logic signed [mrg_pkg::DATA_W-1:0] range_high;

    modport source (output valid, cmd, seed_value, range_low, range_high, input ready);
    modport sink (input valid, cmd, seed_value, range_low, range_high, output ready);
endinterface

interface mrg_rsp_if;
    logic                              valid;
    logic                              ready;
    logic signed [mrg_pkg::DATA_W-1:0] value;
    logic                              range_error;

    modport source (output valid, value, range_error, input ready);
    modport sink (input valid, value, range_error, output ready);
endinterface

`default_nettype wire

// ----- src/mrg_ctrl.sv -----
// Sequencing state machine of the random generator.
// Depends on mrg_pkg for command codes and control/status types.
`default_nettype none

module mrg_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire mrg_pkg::mrg_sts_t sts,
    output mrg_pkg::mrg_ctl_t      ctl
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DEC  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_RED  = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic [mrg_pkg::DIV_CNT_W-1:0] CNT_LAST =
        mrg_pkg::DIV_CNT_W'(mrg_pkg::DIV_STEPS - 1);

    logic [2:0]                      state_reg, state_next;
    logic [mrg_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;

    assign req_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctl        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    ctl.load_in = 1'b1;
                    state_next  = S_DEC;
                end
            end
            S_DEC:
            begin
                priority if (sts.cmd == mrg_pkg::CMD_RAW || sts.cmd == mrg_pkg::CMD_BYTE
                             || sts.cmd == mrg_pkg::CMD_BOOL)
                begin
                    state_next = S_MUL;
                end
                else if (sts.cmd == mrg_pkg::CMD_RANGE)
                begin
                    state_next = sts.range_bad ? S_FIN : S_MUL;
                end
                else if (sts.cmd == mrg_pkg::CMD_SEED)
                begin
                    ctl.seed_load = 1'b1;
                    state_next    = S_FIN;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_MUL:
            begin
                ctl.mul    = 1'b1;
                state_next = S_RED;
            end
            S_RED:
            begin
                // The reduction also primes the remainder unit with the new state.
                ctl.reduce = 1'b1;
                cnt_next   = '0;
                state_next = (sts.cmd == mrg_pkg::CMD_RANGE) ? S_DIV : S_FIN;
            end
            S_DIV:
            begin
                ctl.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    ctl.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/mrg_dp.sv -----
// Datapath of the random generator: state, multiplier, Mersenne reduction,
// seed reduction, bit-serial remainder unit and output register. Depends on mrg_pkg.
`default_nettype none

module mrg_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mrg_pkg::mrg_ctl_t                 ctl,
    output mrg_pkg::mrg_sts_t                      sts,
    input  wire logic [mrg_pkg::CMD_W-1:0]         cmd,
    input  wire logic signed [mrg_pkg::DATA_W-1:0] seed_value,
    input  wire logic signed [mrg_pkg::DATA_W-1:0] range_low,
    input  wire logic signed [mrg_pkg::DATA_W-1:0] range_high,
    input  wire logic                              rsp_ready,
    output logic                                   rsp_valid,
    output logic signed [mrg_pkg::DATA_W-1:0]      rsp_value,
    output logic                                   rsp_range_error
);

    localparam int SW = mrg_pkg::STATE_W;
    localparam int DW = mrg_pkg::DATA_W;
    localparam int PW = mrg_pkg::PROD_W;
    localparam int NW = mrg_pkg::SPAN_W;

    logic [mrg_pkg::CMD_W-1:0] cmd_reg;
    logic [DW-1:0]             seed_reg;
    logic [DW-1:0]             low_reg;
    logic [NW-1:0]             span_reg;
    logic                      bad_reg;
    logic [SW-1:0]             gen_reg, gen_next;
    logic [PW-1:0]             prod_reg;
    logic [SW-1:0]             dvd_reg;
    logic [DW-1:0]             rem_reg;
    logic                      valid_reg;
    logic [DW-1:0]             value_reg, value_next;
    logic                      err_reg, err_next;

    logic [DW-1:0]  red_sum, red_val;
    logic [DW-1:0]  seed_mod;
    logic [SW-1:0]  seed_state;
    logic [NW-1:0]  span_in;
    logic [NW-1:0]  trial;
    logic [NW:0]    trial_diff;

    // Product is below 2^47, so hi + lo folds it below twice the modulus.
    assign red_sum = DW'(prod_reg[PW-1:SW]) + DW'(prod_reg[SW-1:0]);
    assign red_val = (red_sum >= mrg_pkg::LCG_MOD) ? red_sum - mrg_pkg::LCG_MOD : red_sum;

    // A negative seed gets the modulus added once; the most negative seed is the
    // only one that needs it twice.
    always_comb
    begin
        priority if (seed_reg == mrg_pkg::LCG_MOD)
        begin
            seed_mod = '0;
        end
        else if (seed_reg == {1'b1, {(DW-1){1'b0}}})
        begin
            seed_mod = mrg_pkg::LCG_MOD - 1'b1;
        end
        else if (seed_reg[DW-1])
        begin
            seed_mod = seed_reg + mrg_pkg::LCG_MOD;
        end
        else
        begin
            seed_mod = seed_reg;
        end
    end
    assign seed_state = (seed_mod == '0) ? mrg_pkg::STATE_RESET : seed_mod[SW-1:0];

    assign span_in = {range_high[DW-1], range_high} - {range_low[DW-1], range_low} + 1'b1;

    assign trial      = {rem_reg, dvd_reg[SW-1]};
    assign trial_diff = {1'b0, trial} - {1'b0, span_reg};

    always_comb
    begin
        gen_next = gen_reg;
        if (ctl.reduce)
        begin
            gen_next = red_val[SW-1:0];
        end
        else if (ctl.seed_load)
        begin
            gen_next = seed_state;
        end
    end

    always_comb
    begin
        value_next = '0;
        err_next   = 1'b0;
        unique case (cmd_reg)
            mrg_pkg::CMD_RAW:   value_next = DW'(gen_reg);
            mrg_pkg::CMD_BYTE:  value_next = DW'(gen_reg[7:0]);
            mrg_pkg::CMD_BOOL:  value_next = DW'(gen_reg[0]);
            mrg_pkg::CMD_RANGE:
            begin
                if (bad_reg)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    value_next = rem_reg + low_reg;
                end
            end
            mrg_pkg::CMD_SEED:  value_next = DW'(gen_reg);
            mrg_pkg::CMD_READ:  value_next = DW'(gen_reg);
            default:            value_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gen_reg   <= mrg_pkg::STATE_RESET;
            cmd_reg   <= mrg_pkg::CMD_READ;
            bad_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            gen_reg <= gen_next;
            if (ctl.load_in)
            begin
                cmd_reg <= cmd;
                bad_reg <= (range_high < range_low);
            end
            if (ctl.out_load)
            begin
                valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_in)
        begin
            seed_reg <= seed_value;
            low_reg  <= range_low;
            span_reg <= span_in;
        end
        if (ctl.mul)
        begin
            prod_reg <= PW'(gen_reg) * PW'(mrg_pkg::LCG_MULT);
        end
        if (ctl.reduce)
        begin
            dvd_reg <= red_val[SW-1:0];
            rem_reg <= '0;
        end
        else if (ctl.div_step)
        begin
            dvd_reg <= {dvd_reg[SW-2:0], 1'b0};
            rem_reg <= trial_diff[NW] ? trial[DW-1:0] : trial_diff[DW-1:0];
        end
        if (ctl.out_load)
        begin
            value_reg <= value_next;
            err_reg   <= err_next;
        end
    end

    assign sts.cmd       = cmd_reg;
    assign sts.range_bad = bad_reg;
    assign sts.out_free  = !valid_reg || rsp_ready;

    assign rsp_valid       = valid_reg;
    assign rsp_value       = value_reg;
    assign rsp_range_error = err_reg;

endmodule

`default_nettype wire

// ----- src/minstd_random_generator_top.sv -----
// Top level of the minimal-standard random generator; joins controller and
// datapath. Depends on mrg_pkg, mrg_if.sv, mrg_ctrl and mrg_dp.
//
// Park-Miller generator, state' = state * 48271 mod (2^31 - 1), reset state 1.
// One request word gives one response word. Read state, load seed and undefined
// commands go from decode straight to the finish state; raw/byte/bool draws add
// a multiply and a reduction step, and a range draw then runs the bit-serial
// remainder unit, one step per state bit, that reduces the new state modulo the
// 33-bit span. A reversed range goes to finish with range_error set and the
// state kept. A new request is taken only when the previous one has left the
// datapath; the response register lets that happen while an earlier response waits.
`default_nettype none

module minstd_random_generator_top (
    input  wire logic clk,
    input  wire logic rst_n,
    mrg_req_if.sink   req,
    mrg_rsp_if.source rsp
);

    mrg_pkg::mrg_ctl_t ctl;
    mrg_pkg::mrg_sts_t sts;
    logic              req_ready;

    assign req.ready = req_ready;

    mrg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .sts       (sts),
        .ctl       (ctl)
    );

    mrg_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .ctl             (ctl),
        .sts             (sts),
        .cmd             (req.cmd),
        .seed_value      (req.seed_value),
        .range_low       (req.range_low),
        .range_high      (req.range_high),
        .rsp_ready       (rsp.ready),
        .rsp_valid       (rsp.valid),
        .rsp_value       (rsp.value),
        .rsp_range_error (rsp.range_error)
    );

endmodule

`default_nettype wire
